// File: sv/ctmt_pkg.sv
package ctmt_pkg;

  typedef enum logic [2:0] {
    MODE_STANDBY = 3'd0,
    MODE_FAULT   = 3'd1,
    MODE_DEHUM   = 3'd2,
    MODE_FAST    = 3'd3,
    MODE_SLOW    = 3'd4,
    MODE_HEAT    = 3'd5,
    MODE_IDLE    = 3'd6
  } mode_t;

  localparam logic [2:0] MODE_UNDEFINED = 3'd7;

  typedef enum logic [2:0] {
    REG_SETPOINT       = 3'd0,
    REG_HEAT_HYST      = 3'd1,
    REG_DEADBAND       = 3'd2,
    REG_FAST_MARGIN    = 3'd3,
    REG_DOWNSHIFT      = 3'd4,
    REG_AMB_EXCLUSION  = 3'd5,
    REG_DEHUM_MIN      = 3'd6,
    REG_DEHUM_MAX      = 3'd7
  } cfg_reg_t;

  localparam int TEMP_W  = 12;
  localparam int MARGIN_W = 10;
  localparam int WIDE_W  = 14;
  localparam int TICK_W  = 32;

  localparam logic signed [WIDE_W-1:0] EVAP_TARGET            = -14'sd80;
  localparam logic signed [WIDE_W-1:0] EVAP_BAND              = 14'sd32;
  localparam logic        [MARGIN_W-1:0] HUMIDITY_LIMIT       = 10'd800;
  localparam logic signed [WIDE_W-1:0] ENTRY_EVAP_MAX         = 14'sd0;
  localparam logic signed [WIDE_W-1:0] SUBAMBIENT_HEAT_MARGIN = 14'sd32;

  localparam logic signed [WIDE_W-1:0] EVAP_NEAR_LO = EVAP_TARGET - EVAP_BAND;
  localparam logic signed [WIDE_W-1:0] EVAP_NEAR_HI = EVAP_TARGET + EVAP_BAND;

  localparam logic [TEMP_W-1:0]   SETPOINT_RST  = 12'd320;
  localparam logic [MARGIN_W-1:0] HEAT_HYST_RST = 10'd16;
  localparam logic [MARGIN_W-1:0] DEADBAND_RST  = 10'd48;
  localparam logic [MARGIN_W-1:0] FAST_MARGIN_RST = 10'd32;
  localparam logic [MARGIN_W-1:0] DOWNSHIFT_RST = 10'd16;
  localparam logic [MARGIN_W-1:0] AMB_EXCL_RST  = 10'd16;
  localparam logic [TICK_W-1:0]   DEHUM_MIN_RST = 32'd60000;
  localparam logic [TICK_W-1:0]   DEHUM_MAX_RST = 32'd600000;

endpackage

// File: sv/chamber_thermal_mode_transition_top.sv
// an accepted request is first held in the input register, and its result is then written
// to the result register once that register is empty or out_ready takes the result it holds
// throughput: one request per cycle while out_ready keeps up, evaluation is a single pass of compares and adds
// while a result waits for out_ready one more request can still enter the input register
// reset: synchronous active-high rst clears both valid flags and loads
// configuration registers with their default values
module chamber_thermal_mode_transition_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            current_mode,
  input  logic signed [ctmt_pkg::TEMP_W-1:0]    chamber_temp,
  input  logic                                  cool_enable,
  input  logic                                  inhibit_cool_entry,
  input  logic signed [ctmt_pkg::TEMP_W-1:0]    ambient_temp,
  input  logic                                  ambient_valid,
  input  logic signed [ctmt_pkg::TEMP_W-1:0]    evap_temp,
  input  logic                                  evap_valid,
  input  logic [ctmt_pkg::MARGIN_W-1:0]         humidity,
  input  logic [ctmt_pkg::TICK_W-1:0]           now_ticks,
  input  logic [ctmt_pkg::TICK_W-1:0]           entered_at_ticks,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            next_mode,
  output logic                                  mode_changed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [2:0]                            cfg_index,
  input  logic [ctmt_pkg::TICK_W-1:0]           cfg_data
);
  import ctmt_pkg::*;

  // configuration
  logic [TEMP_W-1:0]   setpoint;
  logic [MARGIN_W-1:0] heat_hysteresis;
  logic [MARGIN_W-1:0] deadband;
  logic [MARGIN_W-1:0] fast_cool_margin;
  logic [MARGIN_W-1:0] downshift_margin;
  logic [MARGIN_W-1:0] ambient_exclusion;
  logic [TICK_W-1:0]   dehumidify_min_ticks;
  logic [TICK_W-1:0]   dehumidify_max_ticks;

  // input register
  logic                s1_valid;
  logic [2:0]          s1_mode;
  logic [TEMP_W-1:0]   s1_chamber;
  logic                s1_cool_en;
  logic                s1_inhibit;
  logic [TEMP_W-1:0]   s1_amb;
  logic                s1_amb_ok;
  logic [TEMP_W-1:0]   s1_evap;
  logic                s1_evap_ok;
  logic [MARGIN_W-1:0] s1_hum;
  logic [TICK_W-1:0]   s1_now;
  logic [TICK_W-1:0]   s1_entered;

  logic out_load;

  logic signed [WIDE_W-1:0] sp;
  logic signed [WIDE_W-1:0] chamber;
  logic signed [WIDE_W-1:0] amb;
  logic signed [WIDE_W-1:0] evap;
  logic signed [WIDE_W-1:0] cool_exit;
  logic signed [WIDE_W-1:0] cool_in;
  logic signed [WIDE_W-1:0] fast_entry;
  logic signed [WIDE_W-1:0] slow_entry;
  logic signed [WIDE_W-1:0] heat_start;
  logic signed [WIDE_W-1:0] sub_heat_start;
  logic signed [WIDE_W-1:0] sp_amb_diff;
  logic signed [WIDE_W-1:0] excl;
  logic [TICK_W-1:0]        elapsed;
  logic sp_below_amb;
  logic sp_near_amb;
  logic cooling_ok;
  logic evap_near;
  logic can_enter;
  logic [2:0] idle_next;
  logic [2:0] next_mode_next;

  assign cfg_ready = 1'b1;
  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint             <= SETPOINT_RST;
      heat_hysteresis      <= HEAT_HYST_RST;
      deadband             <= DEADBAND_RST;
      fast_cool_margin     <= FAST_MARGIN_RST;
      downshift_margin     <= DOWNSHIFT_RST;
      ambient_exclusion    <= AMB_EXCL_RST;
      dehumidify_min_ticks <= DEHUM_MIN_RST;
      dehumidify_max_ticks <= DEHUM_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:      setpoint             <= cfg_data[TEMP_W-1:0];
        REG_HEAT_HYST:     heat_hysteresis      <= cfg_data[MARGIN_W-1:0];
        REG_DEADBAND:      deadband             <= cfg_data[MARGIN_W-1:0];
        REG_FAST_MARGIN:   fast_cool_margin     <= cfg_data[MARGIN_W-1:0];
        REG_DOWNSHIFT:     downshift_margin     <= cfg_data[MARGIN_W-1:0];
        REG_AMB_EXCLUSION: ambient_exclusion    <= cfg_data[MARGIN_W-1:0];
        REG_DEHUM_MIN:     dehumidify_min_ticks <= cfg_data;
        REG_DEHUM_MAX:     dehumidify_max_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode    <= current_mode;
      s1_chamber <= chamber_temp;
      s1_cool_en <= cool_enable;
      s1_inhibit <= inhibit_cool_entry;
      s1_amb     <= ambient_temp;
      s1_amb_ok  <= ambient_valid;
      s1_evap    <= evap_temp;
      s1_evap_ok <= evap_valid;
      s1_hum     <= humidity;
      s1_now     <= now_ticks;
      s1_entered <= entered_at_ticks;
    end
  end

  // thresholds, all in a common signed width
  always_comb begin
    sp      = $signed({{(WIDE_W-TEMP_W){setpoint[TEMP_W-1]}}, setpoint});
    chamber = $signed({{(WIDE_W-TEMP_W){s1_chamber[TEMP_W-1]}}, s1_chamber});
    amb     = $signed({{(WIDE_W-TEMP_W){s1_amb[TEMP_W-1]}}, s1_amb});
    evap    = $signed({{(WIDE_W-TEMP_W){s1_evap[TEMP_W-1]}}, s1_evap});
    cool_exit    = sp - $signed({{(WIDE_W-MARGIN_W){1'b0}}, deadband});
    cool_in      = sp + $signed({{(WIDE_W-MARGIN_W){1'b0}}, deadband});
    fast_entry   = cool_in + $signed({{(WIDE_W-MARGIN_W){1'b0}}, fast_cool_margin});
    slow_entry   = sp - $signed({{(WIDE_W-MARGIN_W){1'b0}}, downshift_margin});
    heat_start   = sp - $signed({{(WIDE_W-MARGIN_W){1'b0}}, heat_hysteresis});
    sub_heat_start = sp - SUBAMBIENT_HEAT_MARGIN;
    sp_amb_diff  = sp - amb;
    excl         = $signed({{(WIDE_W-MARGIN_W){1'b0}}, ambient_exclusion});
    elapsed      = s1_now - s1_entered;
    sp_below_amb   = s1_amb_ok && (sp < amb);
    sp_near_amb    = s1_amb_ok && (sp_amb_diff <= excl) && (sp_amb_diff >= -excl);
    cooling_ok     = s1_cool_en && !sp_near_amb;
    evap_near      = s1_evap_ok && (evap >= EVAP_NEAR_LO) && (evap <= EVAP_NEAR_HI);
    can_enter      = cooling_ok && !s1_inhibit;
  end

  // idle rule, also used for the unknown mode code
  always_comb begin
    if (can_enter && chamber >= fast_entry) begin
      idle_next = MODE_FAST;
    end else if (can_enter && chamber >= cool_in) begin
      idle_next = MODE_SLOW;
    end else if (sp_below_amb) begin
      idle_next = (chamber < sub_heat_start) ? MODE_HEAT : MODE_IDLE;
    end else begin
      idle_next = (chamber <= heat_start) ? MODE_HEAT : MODE_IDLE;
    end
  end

  always_comb begin
    case (s1_mode)
      MODE_STANDBY, MODE_FAULT: begin
        next_mode_next = s1_mode;
      end
      MODE_DEHUM: begin
        if (!cooling_ok) begin
          next_mode_next = MODE_IDLE;
        end else if ((elapsed >= dehumidify_max_ticks) ||
                     ((elapsed >= dehumidify_min_ticks) && evap_near)) begin
          next_mode_next = MODE_FAST;
        end else begin
          next_mode_next = MODE_DEHUM;
        end
      end
      MODE_FAST: begin
        if (chamber <= cool_exit || !cooling_ok) begin
          next_mode_next = MODE_IDLE;
        end else if (chamber > 14'sd0 && s1_hum > HUMIDITY_LIMIT && s1_evap_ok &&
                     evap <= ENTRY_EVAP_MAX) begin
          next_mode_next = MODE_DEHUM;
        end else if (chamber <= slow_entry) begin
          next_mode_next = MODE_SLOW;
        end else begin
          next_mode_next = MODE_FAST;
        end
      end
      MODE_SLOW: begin
        if (chamber <= cool_exit || !cooling_ok) begin
          next_mode_next = MODE_IDLE;
        end else if (chamber >= fast_entry) begin
          next_mode_next = MODE_FAST;
        end else begin
          next_mode_next = MODE_SLOW;
        end
      end
      MODE_HEAT: begin
        next_mode_next = (chamber >= sp) ? MODE_IDLE : MODE_HEAT;
      end
      default: begin
        next_mode_next = idle_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_mode    <= next_mode_next;
      mode_changed <= (next_mode_next != s1_mode);
    end
  end

endmodule

// File: sv/ctmt_checker.sv
module ctmt_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [2:0]                           next_mode,
  input logic                                 mode_changed
);
  import ctmt_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_mode) && $stable(mode_changed))
    else $error("stalled result changed");

  // the rule never yields the unused code
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> next_mode != MODE_UNDEFINED)
    else $error("illegal next mode");

  // standby and fault are only reached by passing through
  a_hold_modes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (next_mode == MODE_STANDBY || next_mode == MODE_FAULT) |-> !mode_changed)
    else $error("standby or fault entered from another mode");

  // input side is free whenever no result is pending
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind chamber_thermal_mode_transition_top ctmt_checker u_ctmt_checker (.*);
